// ----- rtl/core/load_cell_average_tare_core_defines.svh -----
// Assertion macros shared by the load cell average and tare core.
`ifndef LOAD_CELL_AVERAGE_TARE_CORE_DEFINES_SVH
`define LOAD_CELL_AVERAGE_TARE_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LCAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define LCAT_ASSERT_NEVER(lbl, cond, msg) \
  `LCAT_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/core/lcat_pkg.sv -----
// Shared constants and types of the load cell average and tare core.
package lcat_pkg;

  // Window depth; the scaling divides by a shift, so it is a power of two.
  localparam int AVG_DEPTH   = 16;
  localparam int IDX_W       = $clog2(AVG_DEPTH);
  localparam int CODE_W      = 24;
  localparam int STATUS_W    = 8;
  localparam int TIME_W      = 32;
  localparam int SUM_W       = CODE_W + IDX_W;
  localparam int GAIN_W      = 20;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int PROD_W      = SUM_W + GAIN_W;
  localparam int Q_SHIFT     = 17;
  localparam int SCALE_SHIFT = Q_SHIFT + IDX_W;
  localparam int QUOT_W      = PROD_W + 1 - SCALE_SHIFT;
  localparam int AVG_W       = 24;
  localparam int MAG_W       = AVG_W - 1;
  localparam int FORCE_W     = 25;
  localparam int AVG_MAX_Q8  = 6600000;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CODE_W-1:0] CODE_MID      = 24'h800000;
  localparam int                STATUS_BUSY   = 7;
  localparam logic [GAIN_W-1:0] UV_GAIN_RESET = 20'd103125;
  localparam logic [TIME_W-1:0] AUTO_TARE_RST = 32'd2000;

  // Item kinds carried in tuser on the input side.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TARE   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UV_GAIN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_TARE = 1'b1;

  // One classified item waiting for the back end.
  typedef struct packed {
    logic                     is_tare;
    logic signed [CODE_W-1:0] raw;
    logic                     late;
  } q_entry_t;

  // Window state after one sample, handed to the scaling pipeline.
  typedef struct packed {
    logic                     valid;
    logic signed [CODE_W-1:0] raw;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  tare;
    logic                     taken;
  } win_res_t;

endpackage

// ----- rtl/core/lcat_front.sv -----
// Front end: accepts input items, drops not-ready samples and classifies the rest.
module lcat_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lcat_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic [lcat_pkg::TIME_W-1:0]    auto_tare_ms,
  input  logic                           full,
  output logic                           push,
  output lcat_pkg::q_entry_t             entry
);
  import lcat_pkg::*;

  logic [STATUS_W-1:0] status_byte;
  logic [CODE_W-1:0]   data_code;
  logic [TIME_W-1:0]   time_ms;
  logic                is_tare;
  logic                drop;

  assign status_byte = s_tdata[STATUS_W-1:0];
  assign data_code   = s_tdata[STATUS_W +: CODE_W];
  assign time_ms     = s_tdata[STATUS_W + CODE_W +: TIME_W];

  assign is_tare  = (s_tuser == FUNC_TARE);
  assign drop     = !is_tare && status_byte[STATUS_BUSY];
  assign s_tready = !full;
  assign push     = s_tvalid && !full && !drop;

  // Offset binary to two's complement is a flip of the top bit.
  assign entry.is_tare = is_tare;
  assign entry.raw     = $signed(data_code ^ CODE_MID);
  assign entry.late    = (time_ms > auto_tare_ms);

endmodule

// ----- rtl/core/lcat_queue.sv -----
// Short queue of classified items between the front and back ends.
`include "load_cell_average_tare_core_defines.svh"

module lcat_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcat_pkg::q_entry_t push_entry,
  input  logic               pop,
  output lcat_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);
  import lcat_pkg::*;

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LCAT_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `LCAT_ASSERT_NEVER(a_push_full, push && full, "push into a full queue")
  `LCAT_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from an empty queue")

endmodule

// ----- rtl/core/lcat_back.sv -----
// Back end: ring of recent samples, running sum and tare capture.
module lcat_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               empty,
  input  lcat_pkg::q_entry_t head,
  output logic               pop,
  output lcat_pkg::win_res_t res
);
  import lcat_pkg::*;

  logic signed [CODE_W-1:0] ring [AVG_DEPTH];
  logic [IDX_W-1:0]         wr_idx;
  logic signed [SUM_W-1:0]  running_sum;
  logic signed [SUM_W-1:0]  tare_sum;
  logic                     tare_valid;

  logic signed [SUM_W-1:0]  sum_next;
  logic [IDX_W-1:0]         idx_next;
  logic                     auto_fire;
  logic                     do_sample;
  logic                     do_tare;

  assign pop       = advance && !empty;
  assign do_tare   = pop && head.is_tare;
  assign do_sample = pop && !head.is_tare;

  assign sum_next  = running_sum - SUM_W'(ring[wr_idx]) + SUM_W'(head.raw);
  assign idx_next  = (wr_idx == IDX_W'(AVG_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
  assign auto_fire = !tare_valid && head.late;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring[i] <= '0;
      end
      wr_idx      <= '0;
      running_sum <= '0;
      tare_sum    <= '0;
      tare_valid  <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (advance) begin
        res.valid <= do_sample;
      end
      if (do_tare) begin
        tare_sum   <= running_sum;
        tare_valid <= 1'b1;
      end
      if (do_sample) begin
        ring[wr_idx] <= head.raw;
        wr_idx       <= idx_next;
        running_sum  <= sum_next;
        res.raw      <= head.raw;
        res.sum      <= sum_next;
        res.taken    <= auto_fire;
        // The automatic tare captures the sum that already holds this sample.
        if (auto_fire) begin
          tare_sum   <= sum_next;
          tare_valid <= 1'b1;
          res.tare   <= sum_next;
        end else begin
          res.tare   <= tare_sum;
        end
      end
    end
  end

endmodule

// ----- rtl/core/lcat_scale.sv -----
// Scaling pipeline: gain multiply, rounding, saturation, tare subtraction, output register.
`include "load_cell_average_tare_core_defines.svh"

module lcat_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  lcat_pkg::win_res_t             res,
  input  logic [lcat_pkg::GAIN_W-1:0]    uv_gain,
  output logic                           advance,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lcat_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import lcat_pkg::*;

  localparam logic signed [AVG_W-1:0]   AVG_HI   = AVG_W'(AVG_MAX_Q8);
  localparam logic signed [FORCE_W-1:0] FORCE_HI = FORCE_W'(2 * AVG_MAX_Q8);

  // Multiply stage.
  logic                     p_valid;
  logic                     p_neg_a;
  logic                     p_neg_t;
  logic [PROD_W-1:0]        p_prod_a;
  logic [PROD_W-1:0]        p_prod_t;
  logic signed [CODE_W-1:0] p_raw;
  logic                     p_taken;

  // Rounded and saturated stage.
  logic                     r_valid;
  logic signed [AVG_W-1:0]  r_avg;
  logic signed [AVG_W-1:0]  r_tare;
  logic signed [CODE_W-1:0] r_raw;
  logic                     r_taken;

  // Output register.
  logic signed [CODE_W-1:0]  raw_code;
  logic signed [AVG_W-1:0]   avg_uv_q8;
  logic signed [FORCE_W-1:0] force_uv_q8;
  logic                      tare_taken;

  logic [SUM_W-1:0]          mag_a;
  logic [SUM_W-1:0]          mag_t;
  logic signed [AVG_W-1:0]   scaled_a;
  logic signed [AVG_W-1:0]   scaled_t;

  logic                      avg_in_range;
  logic                      force_in_range;

  function automatic logic signed [AVG_W-1:0] round_sat(input logic [PROD_W-1:0] prod,
                                                        input logic neg);
    logic [PROD_W:0]    rnd;
    logic [QUOT_W-1:0]  quot;
    logic [MAG_W-1:0]   mag;
    rnd  = {1'b0, prod} + ((PROD_W + 1)'(1) << (SCALE_SHIFT - 1));
    quot = rnd[PROD_W:SCALE_SHIFT];
    if (quot > QUOT_W'(AVG_MAX_Q8)) begin
      mag = MAG_W'(AVG_MAX_Q8);
    end else begin
      mag = quot[MAG_W-1:0];
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign advance = !m_tvalid || m_tready;

  // Magnitudes of the sums; the most negative sum still fits unsigned.
  assign mag_a = res.sum[SUM_W-1]  ? SUM_W'(-res.sum)  : SUM_W'(res.sum);
  assign mag_t = res.tare[SUM_W-1] ? SUM_W'(-res.tare) : SUM_W'(res.tare);

  assign scaled_a = round_sat(p_prod_a, p_neg_a);
  assign scaled_t = round_sat(p_prod_t, p_neg_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      r_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      p_valid  <= res.valid;
      r_valid  <= p_valid;
      m_tvalid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_neg_a     <= res.sum[SUM_W-1];
      p_neg_t     <= res.tare[SUM_W-1];
      p_prod_a    <= PROD_W'(mag_a) * PROD_W'(uv_gain);
      p_prod_t    <= PROD_W'(mag_t) * PROD_W'(uv_gain);
      p_raw       <= res.raw;
      p_taken     <= res.taken;
      r_avg       <= scaled_a;
      r_tare      <= scaled_t;
      r_raw       <= p_raw;
      r_taken     <= p_taken;
      raw_code    <= r_raw;
      avg_uv_q8   <= r_avg;
      force_uv_q8 <= FORCE_W'(r_avg) - FORCE_W'(r_tare);
      tare_taken  <= r_taken;
    end
  end

  assign m_tdata = {(M_TDATA_W - CODE_W - AVG_W - FORCE_W)'(0), force_uv_q8, avg_uv_q8, raw_code};
  assign m_tuser = tare_taken;

  assign avg_in_range   = (avg_uv_q8 <= AVG_HI) && (avg_uv_q8 >= -AVG_HI);
  assign force_in_range = (force_uv_q8 <= FORCE_HI) && (force_uv_q8 >= -FORCE_HI);

  `LCAT_ASSERT(a_avg_bound, m_tvalid |-> avg_in_range, "average out of range")
  `LCAT_ASSERT(a_force_bound, m_tvalid |-> force_in_range, "force out of range")
  `LCAT_ASSERT(a_tare_zero, (m_tvalid && tare_taken) |-> (force_uv_q8 == '0), "auto tare sample not zero")

endmodule

// ----- rtl/core/load_cell_average_tare_core.sv -----
// Top level of the load cell moving average and tare core.
//
//  Channel  Dir  Handshake            Payload (lowest bit first)
//  s        in   s_tvalid/s_tready    tdata: status_byte, data_code, time_ms; tuser: func
//  m        out  m_tvalid/m_tready    tdata: raw_code, avg_uv_q8, force_uv_q8; tuser: tare_taken
//  cfg      in   cfg_we               cfg_index selects uv_gain or auto_tare_ms, cfg_data
//
// One item is accepted per cycle while the four-entry queue has room; a ready
// sample is written into a queue slot at acceptance and then passes the window
// update stage and the three scaling stages into the output register.
// Reset (rst, synchronous) clears the sample ring, the running sum, the tare and
// all valid flags, and loads the register defaults.
// A stall on the output freezes the back end and the scaling pipeline together;
// the front keeps accepting items until the queue fills.
module load_cell_average_tare_core (
  input  logic                              clk,
  input  logic                              rst,
  // Input items.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // status_byte[7:0], data_code[31:8], time_ms[63:32]
  input  logic [lcat_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,   // func[0]
  // Result items.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // raw_code[23:0], avg_uv_q8[47:24], force_uv_q8[72:48], zero pad
  output logic [lcat_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tuser,   // tare_taken[0]
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [lcat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcat_pkg::CFG_W-1:0]        cfg_data
);
  import lcat_pkg::*;

  logic [GAIN_W-1:0] uv_gain;
  logic [TIME_W-1:0] auto_tare_ms;

  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  logic     advance;
  q_entry_t push_entry;
  q_entry_t head;
  win_res_t res;

  // Configuration registers. The user must change them only while the core is idle;
  // the block does not enforce this, and the pipeline reads them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      uv_gain      <= UV_GAIN_RESET;
      auto_tare_ms <= AUTO_TARE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UV_GAIN:   uv_gain      <= cfg_data[GAIN_W-1:0];
        REG_AUTO_TARE: auto_tare_ms <= cfg_data[TIME_W-1:0];
        default:       ;
      endcase
    end
  end

  // The front drops not-ready samples, converts the code to signed and decides
  // whether the sample is late enough for the automatic tare.
  lcat_front u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .auto_tare_ms (auto_tare_ms),
    .full         (full),
    .push         (push),
    .entry        (push_entry)
  );

  lcat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // The back end takes one item per cycle whenever the pipeline moves; tare
  // items update the captured sum and leave a bubble.
  lcat_back u_back (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .res     (res)
  );

  lcat_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .uv_gain  (uv_gain),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- bench/load_cell_reading_checker.sv -----
// Predicts and checks the result items of the load cell average and tare core.
module load_cell_reading_checker
  import lcat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CODE_W-1:0]  raw_code;
    logic signed [AVG_W-1:0]   avg_uv;
    logic signed [FORCE_W-1:0] force_uv;
    logic                      tare_taken;
  } reading_t;

  // Shadow copy of the window, the tare and the registers.
  logic signed [CODE_W-1:0] window_ring [AVG_DEPTH];
  int unsigned              ring_pos;
  longint                   window_sum;
  longint                   tare_window_sum;
  bit                       tare_held;
  logic [GAIN_W-1:0]        gain_reg;
  logic [TIME_W-1:0]        auto_tare_reg;

  reading_t                 readings_due[$];
  reading_t                 predicted;
  reading_t                 observed;
  logic signed [CODE_W-1:0] new_code;
  longint                   avg_q8;
  longint                   tare_q8;

  // Window sum to Q8 microvolts, rounded half away from zero and saturated.
  function automatic longint sum_to_uv_q8(input longint sum);
    longint unsigned mag;
    longint unsigned quot;
    mag  = (sum < 0) ? longint'(-sum) : longint'(sum);
    quot = (mag * gain_reg + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
    if (quot > AVG_MAX_Q8) quot = AVG_MAX_Q8;
    return (sum < 0) ? -longint'(quot) : longint'(quot);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (window_ring[i]) window_ring[i] = '0;
      ring_pos        = 0;
      window_sum      = 0;
      tare_window_sum = 0;
      tare_held       = 1'b0;
      gain_reg        = UV_GAIN_RESET;
      auto_tare_reg   = AUTO_TARE_RST;
      readings_due.delete();
      mismatch_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UV_GAIN:   gain_reg = cfg_data[GAIN_W-1:0];
          REG_AUTO_TARE: auto_tare_reg = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_TARE) begin
          tare_window_sum = window_sum;
          tare_held       = 1'b1;
        end else if (!s_tdata[STATUS_BUSY]) begin
          new_code   = s_tdata[STATUS_W +: CODE_W] - CODE_MID;
          window_sum = window_sum - window_ring[ring_pos] + new_code;
          window_ring[ring_pos] = new_code;
          ring_pos   = (ring_pos + 1) % AVG_DEPTH;
          predicted.tare_taken = 1'b0;
          // The automatic tare captures the sum that already holds this sample.
          if (!tare_held && s_tdata[STATUS_W + CODE_W +: TIME_W] > auto_tare_reg) begin
            tare_window_sum      = window_sum;
            tare_held            = 1'b1;
            predicted.tare_taken = 1'b1;
          end
          avg_q8  = sum_to_uv_q8(window_sum);
          tare_q8 = tare_held ? sum_to_uv_q8(tare_window_sum) : 0;
          predicted.raw_code = new_code;
          predicted.avg_uv   = avg_q8[AVG_W-1:0];
          predicted.force_uv = longint'(avg_q8 - tare_q8) & ((64'd1 << FORCE_W) - 1);
          readings_due.push_back(predicted);
        end
      end

      if (m_tvalid && m_tready) begin
        observed.raw_code   = m_tdata[0 +: CODE_W];
        observed.avg_uv     = m_tdata[CODE_W +: AVG_W];
        observed.force_uv   = m_tdata[CODE_W + AVG_W +: FORCE_W];
        observed.tare_taken = m_tuser;
        if (readings_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result item with none due: raw %0d avg %0d force %0d taken %0b",
                     $realtime, observed.raw_code, observed.avg_uv, observed.force_uv,
                     observed.tare_taken);
          mismatch_count++;
        end else begin
          predicted = readings_due.pop_front();
          if (observed !== predicted) begin
            if (mismatch_count < 10) begin
              $display("%0t: result item differs", $realtime);
              $display("  raw_code    expected %0d got %0d", predicted.raw_code,
                       observed.raw_code);
              $display("  avg_uv_q8   expected %0d got %0d", predicted.avg_uv,
                       observed.avg_uv);
              $display("  force_uv_q8 expected %0d got %0d", predicted.force_uv,
                       observed.force_uv);
              $display("  tare_taken  expected %0b got %0b", predicted.tare_taken,
                       observed.tare_taken);
            end
            mismatch_count++;
          end
        end
      end
    end
    results_pending = readings_due.size();
  end

endmodule

// ----- bench/load_cell_average_tare_core_tb.sv -----
// Top of the testbench: clock, reset, item stimulus, output stalls and the verdict.
module load_cell_average_tare_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcat_pkg::*;

  // Ring depth of the window; a constant burst this long fills it with one code.
  localparam int BURST_LEN    = AVG_DEPTH;
  // Cycles to let pass after the last result so that tare requests, which give no
  // result, have drained out of the queue and pipeline.
  localparam int DRAIN_CYCLES = 20;
  // Length of the receiver's long hold-off, long enough to fill the input queue.
  localparam int HOLD_CYCLES  = 60;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = FUNC_SAMPLE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_UV_GAIN;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int results_pending;

  // Idling controls for the sender and the receiver.
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;
  bit hold_off_req = 1'b0;

  always #2 clk = ~clk;

  load_cell_average_tare_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // status_byte[7:0], data_code[31:8], time_ms[63:32]
    .s_tuser   (s_tuser),   // func[0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // raw_code[23:0], avg_uv_q8[47:24], force_uv_q8[72:48]
    .m_tuser   (m_tuser),   // tare_taken[0]
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  load_cell_reading_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Offers one item from a falling edge and returns at the falling edge after it
  // was taken. The valid is left high so that a following item goes out without a
  // gap; random idle cycles are inserted before the item instead.
  task automatic send_item(input logic kind, input logic [STATUS_W-1:0] status,
                           input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now);
    while (src_gaps_on && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {now, code, status};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // A ready sample: status bit 7 clear, the other status bits random.
  task automatic send_sample(input logic [CODE_W-1:0] code);
    send_item(FUNC_SAMPLE, STATUS_W'($urandom_range(127)), code, $urandom);
  endtask

  // Codes lean toward the rails and the midpoint. Odd multiples of 2^16 make a
  // full window sum whose scaled value sits exactly halfway when the gain is one.
  function automatic logic [CODE_W-1:0] pick_code();
    int pick;
    int mult;
    pick = $urandom_range(99);
    mult = 2 * $urandom_range(63) + 1;
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 25) return CODE_MID;
    if (pick < 30) begin
      if ($urandom_range(1)) return CODE_MID + CODE_W'(mult * 65536);
      return CODE_MID - CODE_W'(mult * 65536);
    end
    return CODE_W'($urandom);
  endfunction

  // Mostly ready samples, with runs of one code that fill the whole window, some
  // tare requests and a few not-ready samples as noise. Not-ready samples leave
  // the block untouched, so they do not count toward the target.
  task automatic run_random(input int target);
    int done;
    int pick;
    logic [CODE_W-1:0] burst_code;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(FUNC_SAMPLE, 8'h80 | STATUS_W'($urandom_range(127)), CODE_W'($urandom),
                  $urandom);
      end else if (pick < 12) begin
        send_item(FUNC_TARE, STATUS_W'($urandom), CODE_W'($urandom), $urandom);
        done++;
      end else if (pick < 22) begin
        burst_code = pick_code();
        repeat (BURST_LEN) send_sample(burst_code);
        done += BURST_LEN;
      end else begin
        send_sample(pick_code());
        done++;
      end
    end
  endtask

  // Drops valid, waits for every predicted result, then lets the items that give
  // no result drain before the registers may be touched.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write; it drops the enable and then waits before returning, so that
  // back-to-back writes never assign the enable twice at one edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random stalls, or one long counted hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= sink_gaps_on ? ($urandom_range(99) >= 13) : 1'b1;
      end
    end
  end

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings (gain 103125, auto tare after 2000 ms).
    // The first samples come before any tare, so force equals the average.
    send_item(FUNC_SAMPLE, 8'h00, 24'h800000, 32'd0);
    // A time equal to the threshold must not yet trigger the automatic tare.
    send_item(FUNC_SAMPLE, 8'h7F, 24'hFFFFFF, 32'd2000);
    // Not-ready samples give nothing, even with a late time stamp.
    send_item(FUNC_SAMPLE, 8'h80, 24'h000000, 32'hFFFFFFFF);
    send_item(FUNC_SAMPLE, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    send_item(FUNC_SAMPLE, 8'h55, 24'h000000, 32'd1999);
    send_item(FUNC_SAMPLE, 8'h2A, 24'h000001, 32'd0);
    // First ready sample past the threshold takes the tare; its force is zero.
    send_item(FUNC_SAMPLE, 8'h01, 24'h7FFFFF, 32'd2001);
    send_item(FUNC_SAMPLE, 8'h00, 24'hFFFFFF, 32'hFFFFFFFF);
    // Tare requests ignore their other fields and replace the existing tare.
    send_item(FUNC_TARE, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    send_item(FUNC_SAMPLE, 8'h7F, 24'h000000, 32'd0);
    send_item(FUNC_TARE, 8'h00, 24'h000000, 32'd0);
    send_item(FUNC_SAMPLE, 8'h40, 24'h800001, 32'd12345);
    run_random(40);
    wait_idle();

    // Largest gain: averages and tares saturate, force reaches both extremes.
    // The upper data bits are set to show that they are masked off.
    write_reg(REG_UV_GAIN, 32'hFFFFFFFF);
    write_reg(REG_AUTO_TARE, 32'd0);
    run_random(20);
    // Long receiver hold-off while items keep coming, so the input stalls.
    hold_off_req = 1'b1;
    run_random(70);
    wait_idle();

    // Zero gain: every scaled value collapses to zero.
    write_reg(REG_UV_GAIN, 32'd0);
    write_reg(REG_AUTO_TARE, 32'hFFFFFFFF);
    run_random(70);
    wait_idle();

    // Unit gain: full windows of odd multiples of 2^16 land exactly on a half.
    write_reg(REG_UV_GAIN, 32'd1);
    write_reg(REG_AUTO_TARE, $urandom);
    run_random(80);
    wait_idle();

    // Random settings with neither side idling.
    write_reg(REG_UV_GAIN, $urandom);
    write_reg(REG_AUTO_TARE, $urandom);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_random(80);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    wait_idle();

    // Back to the nominal converter scaling.
    write_reg(REG_UV_GAIN, 32'd103125);
    write_reg(REG_AUTO_TARE, 32'd2000);
    run_random(90);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lcat_pkg.sv
rtl/core/lcat_front.sv
rtl/core/lcat_queue.sv
rtl/core/lcat_back.sv
rtl/core/lcat_scale.sv
rtl/core/load_cell_average_tare_core.sv
bench/load_cell_reading_checker.sv
bench/load_cell_average_tare_core_tb.sv
